// ===== src/m3sh_pkg.sv =====
// ============================================================================
// m3sh_pkg
// Types and constants shared by the streaming 64-bit message hash.
// ============================================================================
`default_nettype none

package m3sh_pkg;

   localparam logic [63:0] LANE_ONE_INIT = 64'h9368e53c2f6af274;
   localparam logic [63:0] LANE_TWO_INIT = 64'h586dcd208f7cd3fd;
   localparam logic [63:0] MULT_ONE_INIT = 64'h87c37b91114253d5;
   localparam logic [63:0] MULT_TWO_INIT = 64'h4cf5ad432745937f;
   localparam logic [63:0] LANE_ONE_ADD  = 64'h0000000052dce729;
   localparam logic [63:0] LANE_TWO_ADD  = 64'h0000000038495ab5;
   localparam logic [63:0] MULT_ONE_ADD  = 64'h000000007b7d159c;
   localparam logic [63:0] MULT_TWO_ADD  = 64'h000000006bce6396;
   localparam logic [63:0] FMIX_ONE      = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FMIX_TWO      = 64'hc4ceb9fe1a85ec53;
   localparam logic [31:0] SEED_RESET    = 32'hbaadf00d;
   localparam logic [4:0]  BLOCK_BYTES   = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_MIX_WAIT,
      ST_MERGE_A,
      ST_MERGE_B,
      ST_MERGE_C,
      ST_FIN_A,
      ST_FIN_B,
      ST_FIN_C,
      ST_FIN_WAIT,
      ST_FIN_SUM
   } state_type;

   typedef struct packed {
      logic start;
      logic fmix;
   } lane_ctl_type;

   function automatic logic [63:0] rotl64(input logic [63:0] v, input logic [5:0] r);
      logic [127:0] d;
      d = {v, v} << r;
      return d[127:64];
   endfunction

   function automatic logic [63:0] xsh33(input logic [63:0] v);
      return v ^ (v >> 33);
   endfunction

endpackage

`default_nettype wire

// ===== src/m3sh_lane.sv =====
// ============================================================================
// m3sh_lane
// One hash lane: two chained 64-bit multiplies with a pre, middle and post
// operation, used for the block mix and for the 64-bit finalizer.
// ============================================================================
`default_nettype none

module m3sh_lane (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire m3sh_pkg::lane_ctl_type ctl,
   input  wire logic [63:0]           operand,
   input  wire logic [63:0]           k1,
   input  wire logic [63:0]           k2,
   output logic                       done,
   output logic [63:0]                result
);
   import m3sh_pkg::*;

   logic        vld1_ff, vld2_ff, vld3_ff, done_ff;
   logic        fmix1_ff, fmix2_ff, fmix3_ff;
   logic [63:0] k2_s1_ff, k2_s2_ff;
   logic [63:0] pll1_ff, pll1_in;
   logic [31:0] plh1_ff, plh1_in, phl1_ff, phl1_in;
   logic [63:0] v1_ff, v1_in;
   logic [63:0] pll2_ff, pll2_in;
   logic [31:0] plh2_ff, plh2_in, phl2_ff, phl2_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] v0, prod1, prod2;

   always_comb begin
      v0      = ctl.fmix ? xsh33(operand) : operand;
      pll1_in = 64'(v0[31:0]) * 64'(k1[31:0]);
      plh1_in = v0[31:0] * k1[63:32];
      phl1_in = v0[63:32] * k1[31:0];
      prod1   = pll1_ff + {plh1_ff + phl1_ff, 32'd0};
      v1_in   = fmix1_ff ? xsh33(prod1) : rotl64(prod1, 6'd23);
      pll2_in = 64'(v1_ff[31:0]) * 64'(k2_s2_ff[31:0]);
      plh2_in = v1_ff[31:0] * k2_s2_ff[63:32];
      phl2_in = v1_ff[63:32] * k2_s2_ff[31:0];
      prod2   = pll2_ff + {plh2_ff + phl2_ff, 32'd0};
      res_in  = fmix3_ff ? xsh33(prod2) : prod2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         vld1_ff <= ctl.start;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         done_ff <= vld3_ff;
      end
      pll1_ff  <= pll1_in;
      plh1_ff  <= plh1_in;
      phl1_ff  <= phl1_in;
      fmix1_ff <= ctl.fmix;
      k2_s1_ff <= k2;
      v1_ff    <= v1_in;
      fmix2_ff <= fmix1_ff;
      k2_s2_ff <= k2_s1_ff;
      pll2_ff  <= pll2_in;
      plh2_ff  <= plh2_in;
      phl2_ff  <= phl2_in;
      fmix3_ff <= fmix2_ff;
      res_ff   <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

`default_nettype wire

// ===== src/murmur3_x64_stream_hash.sv =====
// ============================================================================
// murmur3_x64_stream_hash
// Streaming 64-bit message hash over 16-byte blocks with two parallel lanes.
// ============================================================================
// A non-final item occupies the block through the lane mix and the merge
// states; a final item also runs the finalizer (skipping the block mix when
// its byte count is zero) and waits while an unread earlier hash still holds
// the output register. No new item is accepted until the last one is done.
// The hash is valid at the output in the same cycle that ready returns.
// Synchronous reset loads seed 0xbaadf00d and the initial hash state.
`default_nettype none

module murmur3_x64_stream_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_word_low,
   input  wire logic [63:0] req_word_high,
   input  wire logic [4:0]  req_byte_count,
   input  wire logic        req_is_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_hash_value,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_seed
);
   import m3sh_pkg::*;

   state_type    state_ff, state_in;
   logic [31:0]  seed_ff, seed_in;
   logic [63:0]  l1_ff, l1_in, l2_ff, l2_in, m1_ff, m1_in, m2_ff, m2_in;
   logic [31:0]  len_ff, len_in;
   logic [63:0]  lo_ff, lo_in, hi_ff, hi_in, a_ff, a_in, b_ff, b_in;
   logic         last_ff, last_in, mix_ff, mix_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [63:0]  hash_ff, hash_in;
   logic [4:0]   cnt;
   logic [63:0]  lo_mask, hi_mask, l2x;
   lane_ctl_type ctl;
   logic [63:0]  op_a, op_b, ka1, ka2, kb1, kb2, res_a, res_b;
   logic         done_a, done_b;
   logic         accept;

   m3sh_lane u_lane_a (
      .clock(clock), .reset(reset), .ctl(ctl), .operand(op_a),
      .k1(ka1), .k2(ka2), .done(done_a), .result(res_a)
   );

   m3sh_lane u_lane_b (
      .clock(clock), .reset(reset), .ctl(ctl), .operand(op_b),
      .k1(kb1), .k2(kb2), .done(done_b), .result(res_b)
   );

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      accept    = req_valid && req_ready;
      csr_ready = 1'b1;

      if (!req_is_last || req_byte_count > BLOCK_BYTES) begin
         cnt = BLOCK_BYTES;
      end else begin
         cnt = req_byte_count;
      end
      for (int i = 0; i < 8; i++) begin
         lo_mask[8*i +: 8] = (cnt > 5'(i)) ? 8'hff : 8'h00;
         hi_mask[8*i +: 8] = (cnt > 5'(i + 8)) ? 8'hff : 8'h00;
      end

      state_in     = state_ff;
      seed_in      = seed_ff;
      l1_in        = l1_ff;
      l2_in        = l2_ff;
      m1_in        = m1_ff;
      m2_in        = m2_ff;
      len_in       = len_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      last_in      = last_ff;
      mix_in       = mix_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl.start    = 1'b0;
      ctl.fmix     = 1'b0;
      op_a         = lo_ff;
      op_b         = hi_ff;
      ka1          = m1_ff;
      ka2          = m2_ff;
      kb1          = m2_ff;
      kb2          = m1_ff;
      l2x          = l2_ff ^ 64'(len_ff);

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               lo_in    = req_word_low & lo_mask;
               hi_in    = req_word_high & hi_mask;
               last_in  = req_is_last;
               mix_in   = (cnt != 5'd0);
               len_in   = len_ff + 32'(cnt);
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (mix_ff) begin
               ctl.start = 1'b1;
               state_in  = ST_MIX_WAIT;
            end else begin
               state_in = ST_FIN_A;
            end
         end
         ST_MIX_WAIT: begin
            if (done_a && done_b) begin
               a_in     = res_a;
               b_in     = res_b;
               state_in = ST_MERGE_A;
            end
         end
         ST_MERGE_A: begin
            l1_in    = (l1_ff ^ a_ff) + l2_ff;
            state_in = ST_MERGE_B;
         end
         ST_MERGE_B: begin
            l2_in    = (rotl64(l2_ff, 6'd41) ^ b_ff) + l1_ff;
            l1_in    = (l1_ff << 1) + l1_ff + LANE_ONE_ADD;
            m1_in    = (m1_ff << 2) + m1_ff + MULT_ONE_ADD;
            m2_in    = (m2_ff << 2) + m2_ff + MULT_TWO_ADD;
            state_in = ST_MERGE_C;
         end
         ST_MERGE_C: begin
            l2_in    = (l2_ff << 1) + l2_ff + LANE_TWO_ADD;
            state_in = last_ff ? ST_FIN_A : ST_IDLE;
         end
         ST_FIN_A: begin
            l2_in    = l2x;
            l1_in    = l1_ff + l2x;
            state_in = ST_FIN_B;
         end
         ST_FIN_B: begin
            l2_in    = l2_ff + l1_ff;
            state_in = ST_FIN_C;
         end
         ST_FIN_C: begin
            ctl.start = 1'b1;
            ctl.fmix  = 1'b1;
            state_in  = ST_FIN_WAIT;
         end
         ST_FIN_WAIT: begin
            ctl.fmix = 1'b1;
            if (done_a && done_b) begin
               a_in     = res_a;
               b_in     = res_b;
               state_in = ST_FIN_SUM;
            end
         end
         ST_FIN_SUM: begin
            if (!rsp_valid_ff || rsp_ready) begin
               hash_in      = a_ff + b_ff;
               rsp_valid_in = 1'b1;
               l1_in        = LANE_ONE_INIT ^ 64'(seed_ff);
               l2_in        = LANE_TWO_INIT ^ 64'(seed_ff);
               m1_in        = MULT_ONE_INIT;
               m2_in        = MULT_TWO_INIT;
               len_in       = 32'd0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (state_ff inside {ST_FIN_C, ST_FIN_WAIT}) begin
         op_a = l1_ff;
         op_b = l2_ff;
         ka1  = FMIX_ONE;
         ka2  = FMIX_TWO;
         kb1  = FMIX_ONE;
         kb2  = FMIX_TWO;
      end

      if (csr_valid && csr_ready) begin
         seed_in = csr_seed;
         l1_in   = LANE_ONE_INIT ^ 64'(csr_seed);
         l2_in   = LANE_TWO_INIT ^ 64'(csr_seed);
         m1_in   = MULT_ONE_INIT;
         m2_in   = MULT_TWO_INIT;
         len_in  = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= SEED_RESET;
         l1_ff        <= LANE_ONE_INIT ^ 64'(SEED_RESET);
         l2_ff        <= LANE_TWO_INIT ^ 64'(SEED_RESET);
         m1_ff        <= MULT_ONE_INIT;
         m2_ff        <= MULT_TWO_INIT;
         len_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         l1_ff        <= l1_in;
         l2_ff        <= l2_in;
         m1_ff        <= m1_in;
         m2_ff        <= m2_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      last_ff <= last_in;
      mix_ff  <= mix_in;
      hash_ff <= hash_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

endmodule

`default_nettype wire
